// ===== src/kpsd_pkg.sv =====
// Package for the keypad scan digit shifter.
// Widths, codes and the state and result structs shared by the step logic and the top level.
// No dependencies.
package kpsd_pkg;

   localparam int DIGIT_COUNT = 8;
   localparam int DIGIT_W     = 5;
   localparam int COL_W       = 4;
   localparam int ROW_W       = 2;
   localparam int DIGITS_W    = 40;

   localparam logic [DIGIT_W-1:0] BLANK_CODE = DIGIT_W'(16);
   localparam logic [COL_W-1:0]   ROW0_DRIVE = COL_W'(8);

   localparam logic [COL_W-1:0] COL_KEY1 = COL_W'(8);
   localparam logic [COL_W-1:0] COL_KEY2 = COL_W'(4);
   localparam logic [COL_W-1:0] COL_KEY3 = COL_W'(2);
   localparam logic [COL_W-1:0] COL_KEY4 = COL_W'(1);

   typedef logic [DIGIT_COUNT-1:0][DIGIT_W-1:0] digit_bank_type;

   typedef struct packed {
      logic [ROW_W-1:0] row_index;
      logic             lockout;
      logic             direction_mode;
      digit_bank_type   digit_store;
   } scan_state_type;

   typedef struct packed {
      logic [COL_W-1:0]    row_drive;
      logic [DIGITS_W-1:0] digits;
      logic                display_changed;
      logic                locked;
      logic                shift_mode;
   } scan_result_type;

endpackage

// ===== src/kpsd_step.sv =====
// Next-state and result logic for one keypad polling item.
// Depends on kpsd_pkg.
module kpsd_step
   import kpsd_pkg::*;
(
   input  scan_state_type   cur_state,
   input  logic [COL_W-1:0] column_bits,
   input  logic             button_down,
   output scan_state_type   nxt_state,
   output scan_result_type  result
);

   logic [COL_W-1:0]   key_low;
   logic [ROW_W-1:0]   key_col;
   logic               key_valid;
   logic [DIGIT_W-1:0] key_code;
   logic               changed;

   always_comb begin
      key_col   = '0;
      key_valid = 1'b1;
      unique case (column_bits)
         COL_KEY1: key_col = ROW_W'(0);
         COL_KEY2: key_col = ROW_W'(1);
         COL_KEY3: key_col = ROW_W'(2);
         COL_KEY4: key_col = ROW_W'(3);
         default:  key_valid = 1'b0;
      endcase
      // row*4 + col + 1, key 16 wraps to 0 in four bits
      key_low  = {cur_state.row_index, 2'b00} + {2'b00, key_col} + COL_W'(1);
      key_code = {1'b0, key_low};
   end

   always_comb begin
      nxt_state = cur_state;
      changed   = 1'b0;
      if (!cur_state.lockout) begin
         if (button_down) begin
            nxt_state.digit_store    = {DIGIT_COUNT{BLANK_CODE}};
            nxt_state.direction_mode = !cur_state.direction_mode;
            nxt_state.lockout        = 1'b1;
            changed                  = 1'b1;
         end else begin
            nxt_state.row_index = cur_state.row_index + ROW_W'(1);
            if (key_valid) begin
               if (!cur_state.direction_mode) begin
                  nxt_state.digit_store =
                     {cur_state.digit_store[DIGIT_COUNT-2:0], key_code};
               end else begin
                  nxt_state.digit_store =
                     {key_code, cur_state.digit_store[DIGIT_COUNT-1:1]};
               end
               nxt_state.lockout = 1'b1;
               changed           = 1'b1;
            end
         end
      end else if (!button_down && column_bits == '0) begin
         nxt_state.lockout = 1'b0;
      end
   end

   always_comb begin
      result.row_drive       = ROW0_DRIVE >> nxt_state.row_index;
      result.digits          = DIGITS_W'(nxt_state.digit_store);
      result.display_changed = changed;
      result.locked          = nxt_state.lockout;
      result.shift_mode      = nxt_state.direction_mode;
   end

endmodule

// ===== src/keypad_scan_digit_shifter_top.sv =====
// Top level of the keypad scan digit shifter: input register, scan state, result register.
// Depends on kpsd_pkg and kpsd_step.
//
//   channel | ports                                  | direction
//   req     | req_valid/ready, column_bits, button   | in
//   rsp     | rsp_valid/ready, row_drive .. shift    | out
//
// One item per clock sustained unless rsp_ready stalls; path: input register, result register.
// State advances when an item moves from the input register into the result register.
// Synchronous reset clears valid flags and scan state; all digits reset to blank.
// A stalled result holds in its register; the input register still takes an item
// while it is empty or the result register is free or being emptied.
module keypad_scan_digit_shifter_top
   import kpsd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [COL_W-1:0]    req_column_bits,
   input  logic                req_button_down,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [COL_W-1:0]    rsp_row_drive,
   output logic [DIGITS_W-1:0] rsp_digits,
   output logic                rsp_display_changed,
   output logic                rsp_locked,
   output logic                rsp_shift_mode
);

   logic             in_valid_ff;
   logic [COL_W-1:0] in_cols_ff;
   logic             in_btn_ff;

   scan_state_type   state_ff;
   scan_state_type   state_in;
   scan_result_type  result_in;
   scan_result_type  result_ff;
   logic             out_valid_ff;

   logic out_free;
   logic advance;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;

   kpsd_step u_step (
      .cur_state   (state_ff),
      .column_bits (in_cols_ff),
      .button_down (in_btn_ff),
      .nxt_state   (state_in),
      .result      (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
      if (req_valid && req_ready) begin
         in_cols_ff <= req_column_bits;
         in_btn_ff  <= req_button_down;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.row_index      <= '0;
         state_ff.lockout        <= 1'b0;
         state_ff.direction_mode <= 1'b0;
         state_ff.digit_store    <= {DIGIT_COUNT{BLANK_CODE}};
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= in_valid_ff;
      end
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_row_drive       = result_ff.row_drive;
   assign rsp_digits          = result_ff.digits;
   assign rsp_display_changed = result_ff.display_changed;
   assign rsp_locked          = result_ff.locked;
   assign rsp_shift_mode      = result_ff.shift_mode;

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for keypad_scan_digit_shifter_top: a directed table, then random
// key, button and noise sequences under four idle/stall phases, checked against a predictor.
// Depends on kpsd_pkg and the RTL under src.
`timescale 1ns / 100ps

module tb;
   import kpsd_pkg::*;

   localparam int DIR_ROWS     = 25;
   localparam int PHASE_ITEMS  = 100;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int MAX_REPORTS  = 10;
   localparam int DRAIN_CYCLES = 8;
   localparam logic [DIGIT_W-1:0]  KEY_WRAP  = DIGIT_W'(16);
   localparam logic [DIGITS_W-1:0] ALL_BLANK = {DIGIT_COUNT{BLANK_CODE}};

   typedef struct {
      logic [COL_W-1:0] cols;
      logic             btn;
      bit               typed;
      scan_result_type  result;
   } stim_row_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [COL_W-1:0]    req_column_bits = '0;
   logic                req_button_down = 1'b0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [COL_W-1:0]    rsp_row_drive;
   logic [DIGITS_W-1:0] rsp_digits;
   logic                rsp_display_changed;
   logic                rsp_locked;
   logic                rsp_shift_mode;

   // predictor state
   logic [ROW_W-1:0] kp_row;
   logic             kp_lock;
   logic             kp_mode;
   digit_bank_type   kp_digits;

   scan_result_type expected_scans [$];
   stim_row_type    dir_table [DIR_ROWS];

   int send_gap_pct = 0;
   int stall_pct    = 0;
   int mismatches   = 0;
   int checked      = 0;
   int ticks_sent   = 0;
   int key_inserts  = 0;
   int mode_toggles = 0;
   int cycles       = 0;

   keypad_scan_digit_shifter_top u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_column_bits     (req_column_bits),
      .req_button_down     (req_button_down),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_row_drive       (rsp_row_drive),
      .rsp_digits          (rsp_digits),
      .rsp_display_changed (rsp_display_changed),
      .rsp_locked          (rsp_locked),
      .rsp_shift_mode      (rsp_shift_mode)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results outstanding",
                  cycles, expected_scans.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   function automatic scan_result_type scan_tick(input logic [COL_W-1:0] cols,
                                                 input logic btn);
      scan_result_type r;
      logic [DIGIT_W-1:0] key;
      logic hit;
      r.display_changed = 1'b0;
      if (!kp_lock && btn) begin
         kp_digits = {DIGIT_COUNT{BLANK_CODE}};
         kp_mode = ~kp_mode;
         kp_lock = 1'b1;
         r.display_changed = 1'b1;
         mode_toggles++;
      end
      if (!kp_lock) begin
         hit = 1'b1;
         key = {1'b0, kp_row, 2'b00};
         case (cols)
            COL_KEY1: key = key + DIGIT_W'(1);
            COL_KEY2: key = key + DIGIT_W'(2);
            COL_KEY3: key = key + DIGIT_W'(3);
            COL_KEY4: key = key + DIGIT_W'(4);
            default:  hit = 1'b0;
         endcase
         if (key == KEY_WRAP) key = '0;
         kp_row = kp_row + 1'b1;
         if (hit) begin
            if (!kp_mode) kp_digits = {kp_digits[DIGIT_COUNT-2:0], key};
            else kp_digits = {key, kp_digits[DIGIT_COUNT-1:1]};
            kp_lock = 1'b1;
            r.display_changed = 1'b1;
            key_inserts++;
         end
      end else if (!btn && cols == '0) begin
         kp_lock = 1'b0;
      end
      r.row_drive  = ROW0_DRIVE >> kp_row;
      r.digits     = kp_digits;
      r.locked     = kp_lock;
      r.shift_mode = kp_mode;
      return r;
   endfunction

   task automatic drive_tick(input logic [COL_W-1:0] cols, input logic btn,
                             input bit typed, input scan_result_type typed_result);
      int gap;
      scan_result_type predicted;
      gap = 0;
      while (gap < 20 && $urandom_range(99) < send_gap_pct) gap++;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_column_bits <= cols;
      req_button_down <= btn;
      do @(posedge clock); while (req_ready !== 1'b1);
      predicted = scan_tick(cols, btn);
      expected_scans.push_back(typed ? typed_result : predicted);
      ticks_sent++;
   endtask

   task automatic check_field(input string fname, input logic [DIGITS_W-1:0] want,
                              input logic [DIGITS_W-1:0] got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= MAX_REPORTS)
            $display("Mismatch on %s at result %0d: expected 0x%0h, got 0x%0h",
                     fname, checked, want, got);
      end
   endtask

   always @(negedge clock) begin
      if (!reset) rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      scan_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_scans.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("Unexpected result: row_drive 0x%0h digits 0x%0h",
                        rsp_row_drive, rsp_digits);
         end else begin
            want = expected_scans.pop_front();
            check_field("row_drive", DIGITS_W'(want.row_drive), DIGITS_W'(rsp_row_drive));
            check_field("digits", want.digits, rsp_digits);
            check_field("display_changed", DIGITS_W'(want.display_changed),
                        DIGITS_W'(rsp_display_changed));
            check_field("locked", DIGITS_W'(want.locked), DIGITS_W'(rsp_locked));
            check_field("shift_mode", DIGITS_W'(want.shift_mode), DIGITS_W'(rsp_shift_mode));
            checked++;
         end
      end
   end

   initial begin
      int phase;
      int phase_start;
      int kind;
      int n;
      logic [COL_W-1:0] cols;
      int gap_table [4];
      int stall_table [4];

      gap_table   = '{0, 50, 0, 20};
      stall_table = '{0, 0, 50, 20};

      // button first, then keys across rows, wrap key, multi-bit columns, mode 1 inserts
      dir_table = '{
         '{4'h0, 1'b1, 1'b1, '{ROW0_DRIVE, ALL_BLANK, 1'b1, 1'b1, 1'b1}},
         '{4'h0, 1'b0, 1'b1, '{ROW0_DRIVE, ALL_BLANK, 1'b0, 1'b0, 1'b1}},
         '{COL_KEY1, 1'b1, 1'b1, '{ROW0_DRIVE, ALL_BLANK, 1'b1, 1'b1, 1'b0}},
         '{4'h0, 1'b0, 1'b0, '0},
         '{COL_KEY1, 1'b0, 1'b0, '0},
         '{COL_KEY1, 1'b0, 1'b0, '0},
         '{4'h0, 1'b0, 1'b0, '0},
         '{4'hF, 1'b0, 1'b0, '0},
         '{COL_KEY2, 1'b0, 1'b0, '0},
         '{4'h0, 1'b0, 1'b0, '0},
         '{COL_KEY4, 1'b0, 1'b0, '0},
         '{4'h0, 1'b0, 1'b0, '0},
         '{4'h0, 1'b0, 1'b0, '0},
         '{4'h6, 1'b0, 1'b0, '0},
         '{COL_KEY3, 1'b0, 1'b0, '0},
         '{COL_KEY3, 1'b1, 1'b0, '0},
         '{4'h0, 1'b0, 1'b0, '0},
         '{4'h0, 1'b1, 1'b0, '0},
         '{4'h0, 1'b0, 1'b0, '0},
         '{COL_KEY4, 1'b0, 1'b0, '0},
         '{4'h0, 1'b0, 1'b0, '0},
         '{COL_KEY2, 1'b0, 1'b0, '0},
         '{4'h0, 1'b0, 1'b0, '0},
         '{COL_KEY3, 1'b0, 1'b0, '0},
         '{4'h0, 1'b0, 1'b0, '0}
      };

      kp_row    = '0;
      kp_lock   = 1'b0;
      kp_mode   = 1'b0;
      kp_digits = {DIGIT_COUNT{BLANK_CODE}};

      repeat (10) @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIR_ROWS; i++)
         drive_tick(dir_table[i].cols, dir_table[i].btn, dir_table[i].typed,
                    dir_table[i].result);

      for (phase = 0; phase < 4; phase++) begin
         send_gap_pct = gap_table[phase];
         stall_pct    = stall_table[phase];
         phase_start  = ticks_sent;
         while (ticks_sent - phase_start < PHASE_ITEMS) begin
            kind = $urandom_range(99);
            if (kind < 50) begin
               // idle scans to move the row, a key, bounce while held, release
               n = $urandom_range(3);
               repeat (n) drive_tick('0, 1'b0, 1'b0, '0);
               cols = COL_W'(1) << $urandom_range(COL_W-1);
               drive_tick(cols, 1'b0, 1'b0, '0);
               n = $urandom_range(2);
               repeat (n) drive_tick(COL_W'($urandom_range(1, 15)), 1'($urandom_range(1)),
                                     1'b0, '0);
               drive_tick('0, 1'b0, 1'b0, '0);
            end else if (kind < 65) begin
               drive_tick(COL_W'($urandom_range(15)), 1'b1, 1'b0, '0);
               drive_tick('0, 1'b0, 1'b0, '0);
            end else begin
               drive_tick(COL_W'($urandom_range(15)), 1'($urandom_range(1)), 1'b0, '0);
            end
         end
      end

      @(negedge clock);
      req_valid <= 1'b0;
      stall_pct = 0;
      while (expected_scans.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Drove %0d scan ticks (%0d from the directed table) over four idle/stall phases",
               ticks_sent, DIR_ROWS);
      $display("Checked %0d results: %0d key inserts, %0d mode toggles, %0d mismatches",
               checked, key_inserts, mode_toggles, mismatches);
      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
